// File: design/hsbe_pkg.sv
package hsbe_pkg;

  // Offset counter width and number of bodies that are marked as kept
  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned MAX_SPANS   = 16;

  localparam int unsigned FIELD_BITS = 24;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned OPEN_LEN   = 6;
  localparam int unsigned CLOSE_LEN  = 8;
  localparam logic [7:0]  CASE_BIT   = 8'h20;

  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam int unsigned TDATA_BITS = 88;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_NAME  = 3'd2,
    PH_AFTER = 3'd3,
    PH_OPEN  = 3'd4,
    PH_SKIP  = 3'd5,
    PH_BODY  = 3'd6
  } phase_e;

  typedef enum logic {
    KIND_SPAN    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic [FIELD_BITS-1:0]   span_start;
    logic [FIELD_BITS-1:0]   span_length;
    logic [COUNT_BITS-1:0]   span_index;
    logic                    span_stored;
    logic [COUNT_BITS-1:0]   span_count;
    logic                    too_long;
    logic                    last_result;
  } result_t;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + CASE_BIT;
    end
    return c;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    return (l >= 8'h61 && l <= 8'h7A);
  endfunction

  // "script", indexed by match progress
  function automatic logic [7:0] open_char(logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h73;
      4'd1:    return 8'h63;
      4'd2:    return 8'h72;
      4'd3:    return 8'h69;
      4'd4:    return 8'h70;
      4'd5:    return 8'h74;
      default: return 8'h00;
    endcase
  endfunction

  // "</script", indexed by match progress
  function automatic logic [7:0] close_char(logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h3C;
      4'd1:    return 8'h2F;
      4'd2:    return 8'h73;
      4'd3:    return 8'h63;
      4'd4:    return 8'h72;
      4'd5:    return 8'h69;
      4'd6:    return 8'h70;
      4'd7:    return 8'h74;
      default: return 8'h00;
    endcase
  endfunction

  // Clamp an offset to the width of the span fields
  function automatic logic [FIELD_BITS-1:0] sat_field(logic [OFFSET_BITS-1:0] v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > 33'({FIELD_BITS{1'b1}})) begin
      return {FIELD_BITS{1'b1}};
    end
    return wide[FIELD_BITS-1:0];
  endfunction

endpackage

// File: design/html_script_body_extractor.sv
// HTML script body locator.
// Slave stream: one document byte per word in s_axis_tdata[7:0], s_axis_tlast on
// the final byte of the document. Master stream: one result per word; tuser is
// the kind (0 = body span, 1 = end-of-document summary), tlast marks the final
// result caused by one input byte.
// Each byte is decoded by a single pass of the tag/body matcher in the cycle it
// is accepted; its results are registered into a four-entry result queue that
// drives the master side. A new byte is taken every cycle while the queue
// holds at most one result, so with the receiver always ready the block runs at
// one byte per cycle. A byte gives at most two results (a span on the 't' of a
// closing tag, then the summary on the last byte).
// When the receiver stalls, the queue fills and s_axis_tready drops once two
// results are waiting; no result is lost or reordered.
// Reset clears the scan state, counters and the queue. After the last byte the
// block is halted: further bytes are taken and dropped until the next reset.
module html_script_body_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [hsbe_pkg::TDATA_BITS-1:0] m_axis_tdata,
  // [23:0] span_start, [47:24] span_length, [63:48] span_index, [64] span_stored,
  // [80:65] span_count, [81] too_long, [87:82] zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast    // last_result
);
  import hsbe_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFS_TOP = {OFFSET_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  CNT_MAX = {COUNT_BITS{1'b1}};

  // scan state
  phase_e                 phase_q, phase_d;
  logic [3:0]             prog_q, prog_d;
  logic [OFFSET_BITS-1:0] ofs_q, ofs_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [COUNT_BITS-1:0]  seen_q, seen_d;
  logic                   ovf_q, ovf_d;
  logic                   halted_q, halted_d;

  // result queue
  result_t    fifo_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;

  logic                   accept, pop;
  logic [1:0]             push_n;
  result_t                res0, res1, span_res, sum_res;
  logic [7:0]             c, lc;
  logic [OFFSET_BITS-1:0] here, here_inc, lt, len;
  logic                   span_hit;
  logic [3:0]             bprog;

  assign s_axis_tready = (cnt_q <= 3'd1);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  assign c        = s_axis_tdata;
  assign lc       = to_lower(s_axis_tdata);
  assign here     = ofs_q;   // the counter never passes its top
  assign here_inc = (ofs_q == OFS_TOP) ? OFS_TOP : ofs_q + 1'b1;
  // offset of the '<' of the closing tag, clamped at zero
  assign lt       = (here >= OFFSET_BITS'(7)) ? here - OFFSET_BITS'(7) : '0;
  assign len      = (lt >= begin_q) ? lt - begin_q : '0;

  always_comb begin
    phase_d  = phase_q;
    prog_d   = prog_q;
    ofs_d    = ofs_q;
    begin_d  = begin_q;
    seen_d   = seen_q;
    ovf_d    = ovf_q;
    halted_d = halted_q;
    span_hit = 1'b0;
    bprog    = '0;

    if (accept && !halted_q) begin
      if (ofs_q == OFS_TOP) begin
        ovf_d = 1'b1;
      end
      ofs_d = here_inc;

      unique case (phase_q)
        PH_SEEK: begin
          if (c == CH_LT) phase_d = PH_LEAD;
        end
        PH_LEAD: begin
          if (c == CH_SP || c == CH_TAB) begin
            phase_d = PH_LEAD;
          end else if (c == CH_GT) begin
            phase_d = PH_SEEK;
          end else if (lc == open_char(4'd0)) begin
            phase_d = PH_NAME;
            prog_d  = 4'd1;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_NAME: begin
          if (c == CH_GT) begin
            phase_d = PH_SEEK;
          end else if (prog_q < 4'(OPEN_LEN) && lc == open_char(prog_q)) begin
            prog_d = prog_q + 4'd1;
            if (prog_q + 4'd1 >= 4'(OPEN_LEN)) phase_d = PH_AFTER;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_AFTER, PH_OPEN: begin
          if (c == CH_GT) begin
            phase_d = PH_BODY;
            prog_d  = '0;
            begin_d = here_inc;
          end else if (phase_q == PH_AFTER && is_letter(c)) begin
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_OPEN;
          end
        end
        PH_BODY: begin
          if (prog_q < 4'(CLOSE_LEN) && lc == close_char(prog_q)) begin
            bprog = prog_q + 4'd1;
          end else begin
            bprog = (c == CH_LT) ? 4'd1 : 4'd0;
          end
          prog_d = bprog;
          if (bprog >= 4'(CLOSE_LEN)) begin
            span_hit = 1'b1;
            if (seen_q < CNT_MAX) seen_d = seen_q + 1'b1;
            phase_d = PH_SKIP;
            prog_d  = '0;
          end
        end
        PH_SKIP: begin
          if (c == CH_GT) phase_d = PH_SEEK;
        end
        default: begin
          phase_d = PH_SEEK;
          prog_d  = '0;
        end
      endcase

      if (s_axis_tlast) halted_d = 1'b1;
    end
  end

  // result words for this byte
  always_comb begin
    span_res.kind        = KIND_SPAN;
    span_res.span_start  = sat_field(begin_q);
    span_res.span_length = sat_field(len);
    span_res.span_index  = seen_q;
    span_res.span_stored = (17'(seen_q) < 17'(MAX_SPANS));
    span_res.span_count  = seen_d;
    span_res.too_long    = ovf_d;
    span_res.last_result = !s_axis_tlast;

    sum_res.kind        = KIND_SUMMARY;
    sum_res.span_start  = '0;
    sum_res.span_length = '0;
    sum_res.span_index  = '0;
    sum_res.span_stored = 1'b0;
    sum_res.span_count  = seen_d;
    sum_res.too_long    = ovf_d;
    sum_res.last_result = 1'b1;

    res1   = sum_res;
    push_n = 2'd0;
    res0   = span_res;
    if (accept && !halted_q) begin
      if (span_hit) begin
        res0   = span_res;
        push_n = s_axis_tlast ? 2'd2 : 2'd1;
      end else if (s_axis_tlast) begin
        res0   = sum_res;
        push_n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEEK;
      prog_q   <= '0;
      ofs_q    <= '0;
      begin_q  <= '0;
      seen_q   <= '0;
      ovf_q    <= 1'b0;
      halted_q <= 1'b0;
      wptr_q   <= '0;
      rptr_q   <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      prog_q   <= prog_d;
      ofs_q    <= ofs_d;
      begin_q  <= begin_d;
      seen_q   <= seen_d;
      ovf_q    <= ovf_d;
      halted_q <= halted_d;
      wptr_q   <= wptr_q + push_n;
      if (pop) rptr_q <= rptr_q + 2'd1;
      cnt_q    <= cnt_q + 3'(push_n) - 3'(pop);
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) fifo_q[wptr_q] <= res0;
    if (push_n == 2'd2) fifo_q[wptr_q + 2'd1] <= res1;
  end

  result_t head;
  assign head          = fifo_q[rptr_q];
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last_result;
  assign m_axis_tdata  = {6'd0, head.too_long, head.span_count, head.span_stored,
                          head.span_index, head.span_length, head.span_start};

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("result queue overflow");

  // taking the last byte halts the scan
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> halted_q) else $error("not halted after last byte");

  // a halted block emits nothing new
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (push_n == 2'd0)) else $error("result after halt");

  // a summary always closes the results of its byte
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast) else $error("summary not last");

endmodule

// File: test/tb_html_script_body_extractor.sv
`timescale 1ns / 1ps

module tb_html_script_body_extractor;
  import hsbe_pkg::*;

  typedef struct {
    logic [7:0] value;
    logic       is_end;
  } doc_byte_t;

  localparam logic [OFFSET_BITS-1:0] OFS_TOP   = {OFFSET_BITS{1'b1}};
  localparam logic [8*OPEN_LEN-1:0]  OPEN_TAG  = "script";
  localparam logic [8*CLOSE_LEN-1:0] CLOSE_TAG = "</script";

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  html_script_body_extractor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  doc_byte_t   pending_bytes[$];
  result_t     expected_results[$];
  int unsigned mismatches = 0;

  // Scanner state mirrored from the block
  phase_e                  phase = PH_SEEK;
  logic [3:0]              match_len = '0;
  logic [OFFSET_BITS-1:0]  next_offset = '0;
  logic [OFFSET_BITS-1:0]  body_start = '0;
  logic [COUNT_BITS-1:0]   body_total = '0;
  logic                    offset_overflow = 1'b0;
  logic                    doc_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic logic [FIELD_BITS-1:0] fit_field(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'({FIELD_BITS{1'b1}})) ? {FIELD_BITS{1'b1}} : w[FIELD_BITS-1:0];
  endfunction

  // Advance the scanner by one accepted byte, queue the words it should produce
  task automatic scan_byte(input logic [7:0] c, input logic is_end);
    logic [7:0]             lc;
    logic [OFFSET_BITS-1:0] here;
    logic [OFFSET_BITS-1:0] lt_pos;
    logic [OFFSET_BITS-1:0] body_len;
    result_t                r;
    lc = fold_case(c);
    if (doc_done) begin
      return;
    end
    if (next_offset >= OFS_TOP) begin
      next_offset = OFS_TOP;
      offset_overflow = 1'b1;
    end
    here = next_offset;
    case (phase)
      PH_SEEK: begin
        if (c == CH_LT) phase = PH_LEAD;
      end
      PH_LEAD: begin
        if (c == CH_SP || c == CH_TAB) begin
        end else if (c == CH_GT) begin
          phase = PH_SEEK;
        end else if (lc == OPEN_TAG[8*(OPEN_LEN-1) +: 8]) begin
          phase = PH_NAME;
          match_len = 4'd1;
        end else begin
          phase = PH_SKIP;
        end
      end
      PH_NAME: begin
        if (c == CH_GT) begin
          phase = PH_SEEK;
        end else if (match_len < OPEN_LEN &&
                     lc == OPEN_TAG[8*(OPEN_LEN-1-match_len) +: 8]) begin
          match_len = match_len + 4'd1;
          if (match_len >= OPEN_LEN) phase = PH_AFTER;
        end else begin
          phase = PH_SKIP;
        end
      end
      PH_AFTER, PH_OPEN: begin
        if (c == CH_GT) begin
          phase = PH_BODY;
          match_len = '0;
          body_start = (here == OFS_TOP) ? OFS_TOP : here + 1'b1;
        end else if (phase == PH_AFTER && lc >= "a" && lc <= "z") begin
          phase = PH_SKIP;
        end else begin
          phase = PH_OPEN;
        end
      end
      PH_BODY: begin
        if (match_len < CLOSE_LEN && lc == CLOSE_TAG[8*(CLOSE_LEN-1-match_len) +: 8]) begin
          match_len = match_len + 4'd1;
        end else begin
          match_len = (c == CH_LT) ? 4'd1 : 4'd0;
        end
        if (match_len >= CLOSE_LEN) begin
          // '<' of the closing tag sits seven bytes back
          lt_pos = (here >= OFFSET_BITS'(7)) ? here - OFFSET_BITS'(7) : '0;
          body_len = (lt_pos >= body_start) ? lt_pos - body_start : '0;
          r.kind = KIND_SPAN;
          r.span_start = fit_field(body_start);
          r.span_length = fit_field(body_len);
          r.span_index = body_total;
          r.span_stored = (body_total < MAX_SPANS);
          if (body_total != {COUNT_BITS{1'b1}}) body_total = body_total + 1'b1;
          r.span_count = body_total;
          r.too_long = offset_overflow;
          r.last_result = !is_end;
          expected_results.push_back(r);
          phase = PH_SKIP;
          match_len = '0;
        end
      end
      PH_SKIP: begin
        if (c == CH_GT) phase = PH_SEEK;
      end
      default: begin
        phase = PH_SEEK;
        match_len = '0;
      end
    endcase
    if (next_offset < OFS_TOP) next_offset = next_offset + 1'b1;
    if (is_end) begin
      r.kind = KIND_SUMMARY;
      r.span_start = '0;
      r.span_length = '0;
      r.span_index = '0;
      r.span_stored = 1'b0;
      r.span_count = body_total;
      r.too_long = offset_overflow;
      r.last_result = 1'b1;
      expected_results.push_back(r);
      doc_done = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Document builder
  logic [7:0]  doc[$];
  int unsigned spans_planned = 0;

  task automatic put_text(input string s, input bit mixed_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixed_case && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'h20;
      doc.push_back(c);
    end
  endtask

  // Random byte that cannot end a tag
  function automatic logic [7:0] tag_filler();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    return (c == CH_GT) ? 8'h80 : c;
  endfunction

  // Body content, biased toward partial closing tags
  function automatic logic [7:0] body_filler();
    case ($urandom_range(0, 7))
      0:       return CH_LT;
      1:       return "/";
      2:       return "s";
      3:       return "T";
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic put_script_element();
    doc.push_back(CH_LT);
    repeat ($urandom_range(0, 2)) doc.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
    put_text("script", 1'b1);
    case ($urandom_range(0, 3))
      0: begin
        doc.push_back(CH_SP);
        repeat ($urandom_range(1, 8)) doc.push_back(tag_filler());
      end
      1: doc.push_back(8'($urandom_range(0, 1) ? "1" : "-"));
      default: ;
    endcase
    doc.push_back(CH_GT);
    repeat ($urandom_range(0, 12)) doc.push_back(body_filler());
    put_text("</script", 1'b1);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) doc.push_back(tag_filler());
    end
    doc.push_back(CH_GT);
    spans_planned++;
  endtask

  initial begin
    doc_byte_t w;

    // Directed: leading tab, mixed case, odd bytes and a stray '<' in the body,
    // then an empty tag
    put_text("<\tScript>", 1'b0);
    doc.push_back(8'hFF);
    doc.push_back(CH_LT);
    doc.push_back(8'h80);
    put_text("</SCRIPT>", 1'b0);
    doc.push_back(8'h01);
    put_text("<>", 1'b0);

    while (doc.size() < 900 || spans_planned < 40) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: put_script_element();
        6: repeat ($urandom_range(1, 6)) doc.push_back(8'($urandom_range(1, 255)));
        7: begin
          case ($urandom_range(0, 5))
            0: put_text("<scripts>", 1'b1);
            1: put_text("<scr>", 1'b1);
            2: put_text("<div class=a>", 1'b1);
            3: put_text("< \t>", 1'b0);
            4: put_text("<scrip<t>", 1'b1);
            default: put_text("</script>", 1'b1);
          endcase
        end
        8: begin
          put_text("<script\t>x</scrip>y<</script>", 1'b1);
          spans_planned++;
        end
        default: begin
          put_text("<SCRIPT>", 1'b1);
          repeat ($urandom_range(0, 3)) doc.push_back(body_filler());
          put_text("</scriptx>", 1'b1);
          spans_planned++;
        end
      endcase
    end

    // Tail: close on the final byte (span plus summary), or leave the body or
    // the tag open
    case ($urandom_range(0, 3))
      0: put_text("<script>tail", 1'b1);
      1: put_text("<scri", 1'b1);
      default: put_text("<script>z</script", 1'b1);
    endcase

    foreach (doc[i]) begin
      w.value = doc[i];
      w.is_end = (i == doc.size() - 1);
      pending_bytes.push_back(w);
    end
    // Bytes after the end of the document are dropped by the block
    repeat (3) begin
      w.value = 8'($urandom_range(1, 255));
      w.is_end = 1'($urandom_range(0, 1));
      pending_bytes.push_back(w);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS html_script_body_extractor");
    end else begin
      $display("FAIL html_script_body_extractor");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL html_script_body_extractor");
    $finish;
  end

  // Byte driver: random gap after each word, with calm stretches of no gaps
  int unsigned gap_left = 0;
  bit          src_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    doc_byte_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(s_axis_tdata, s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          w = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= w.value;
          s_axis_tlast  <= w.is_end;
          if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
          gap_left <= src_calm ? 0 : $urandom_range(0, 8);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each word, then may stall for a random hold
  int unsigned stall_left = 0;
  bit          sink_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    result_t     want;
    int unsigned hold;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0b tdata 0x%0h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("span_start", 32'(want.span_start), 32'(m_axis_tdata[23:0]));
        check_field("span_length", 32'(want.span_length), 32'(m_axis_tdata[47:24]));
        check_field("span_index", 32'(want.span_index), 32'(m_axis_tdata[63:48]));
        check_field("span_stored", 32'(want.span_stored), 32'(m_axis_tdata[64]));
        check_field("span_count", 32'(want.span_count), 32'(m_axis_tdata[80:65]));
        check_field("too_long", 32'(want.too_long), 32'(m_axis_tdata[81]));
        check_field("pad", 32'h0, 32'(m_axis_tdata[87:82]));
        check_field("last_result", 32'(want.last_result), 32'(m_axis_tlast));
      end
      if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
      hold = sink_calm ? 0 : $urandom_range(0, 8);
      m_axis_tready <= (hold == 0);
      stall_left <= hold;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

endmodule

// File: files.f
design/hsbe_pkg.sv
design/html_script_body_extractor.sv
test/tb_html_script_body_extractor.sv
